// ===== src/fved_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fved_pkg: shared definitions of the filtered voltage engine detector
// Default widths, register indexes, reset values and state encodings.
// ---------------------------------------------------------------------------
package fved_pkg;

    // Default widths of the sample and of the fixed-point fraction.
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 16;

    // Error values P, R and q are always 32 bits wide.
    localparam int ERR_BITS       = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int COUNT_BITS     = 16;
    localparam int BRIGHT_BITS    = 4;

    // Side-marker brightness levels.
    localparam logic [BRIGHT_BITS-1:0] BRIGHT_RUN  = 4'd10;
    localparam logic [BRIGHT_BITS-1:0] BRIGHT_STOP = 4'd0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MEAS_ERR   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_ERR   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROC_NOISE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCK       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [ERR_BITS-1:0]   RST_MEAS_ERR   = 32'd65536;
    localparam logic [ERR_BITS-1:0]   RST_INIT_ERR   = 32'd65536;
    localparam logic [ERR_BITS-1:0]   RST_PROC_NOISE = 32'd6554;
    localparam int                    RST_THRESHOLD  = 3000;
    localparam logic [COUNT_BITS-1:0] RST_DEBOUNCE   = 16'd100;
    localparam logic                  RST_LOCK       = 1'b1;

    // Sequencer of the serial filter datapath.
    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV  = 5'b00010,
        F_MOVE = 5'b00100,
        F_MUL  = 5'b01000,
        F_DONE = 5'b10000
    } t_fstate;

    // Control of the top level.
    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_HOLD = 3'b100
    } t_tstate;

endpackage
`default_nettype wire

// ===== src/fved_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fved_filter: bit-serial scalar Kalman step
// Divides P by P+R one gain bit per cycle while two shift-add accumulators
// form gain*|d| and gain*P, then multiplies the estimate change by q one bit
// per cycle and forms the saturated new estimate error.
// ---------------------------------------------------------------------------
module fved_filter import fved_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] i_estimate,
    input  logic [ERR_BITS-1:0]                  i_error,
    input  logic [ERR_BITS-1:0]                  i_meas_error,
    input  logic [ERR_BITS-1:0]                  i_proc_noise,
    output logic                                 o_done,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] o_estimate,
    output logic [FRACTION_BITS:0]               o_gain,
    output logic [ERR_BITS-1:0]                  o_error
);

    localparam int EW = SAMPLE_BITS + FRACTION_BITS;  // estimate width
    localparam int GW = FRACTION_BITS + 1;            // gain width
    localparam int MW = EW + GW;                      // gain * |d|
    localparam int PW = ERR_BITS + GW;                // gain * P
    localparam int SW = ERR_BITS + 1;                 // P + R
    localparam int RW = ERR_BITS + 2;                 // divider remainder
    localparam int CW = $clog2(EW + 1);

    t_fstate                r_state;
    t_fstate                n_state;
    logic [CW-1:0]          r_cnt;
    logic [EW-1:0]          r_est;
    logic [ERR_BITS-1:0]    r_p;
    logic [ERR_BITS-1:0]    r_q;
    logic [SW-1:0]          r_sum;
    logic                   r_zero;
    logic [RW-1:0]          r_rem;
    logic                   r_up;
    logic [EW-1:0]          r_dmag;
    logic [GW-1:0]          r_gain;
    logic [MW-1:0]          r_acc_m;
    logic [PW-1:0]          r_acc_p;
    logic [EW-1:0]          r_est_next;
    logic [ERR_BITS-1:0]    r_pa;
    logic [ERR_BITS-1:0]    r_acc_q;
    logic [EW-1:0]          r_mv;

    logic [EW-1:0]                  w_meas;
    logic [SW-1:0]                  w_sum;
    logic                           w_qbit;
    logic [RW-1:0]                  w_rem_sub;
    logic [EW-1:0]                  w_mv;
    logic [ERR_BITS+FRACTION_BITS-1:0] w_gp;
    logic [ERR_BITS+FRACTION_BITS-1:0] w_pa_diff;
    logic [EW-1:0]                  w_est_move;
    logic [SW-1:0]                  w_mul_sum;
    logic                           w_pb_sat;
    logic [ERR_BITS-1:0]            w_pb;
    logic [SW-1:0]                  w_p_total;

    // Setup terms taken when a word starts.
    assign w_meas = {i_sample, {FRACTION_BITS{1'b0}}};
    assign w_sum  = {1'b0, i_error} + {1'b0, i_meas_error};

    // One restoring division step per cycle; the quotient comes out MSB first.
    assign w_qbit    = r_rem >= {1'b0, r_sum};
    assign w_rem_sub = w_qbit ? (r_rem - {1'b0, r_sum}) : r_rem;

    // Estimate move and first part of the error update. A zero denominator
    // forces the gain, and with it both products, to zero.
    assign w_mv       = r_zero ? '0 : r_acc_m[FRACTION_BITS +: EW];
    assign w_gp       = r_zero ? '0 : r_acc_p[ERR_BITS+FRACTION_BITS-1:0];
    assign w_pa_diff  = {r_p, {FRACTION_BITS{1'b0}}} - w_gp;
    assign w_est_move = r_up ? (r_est + w_mv) : (r_est - w_mv);

    // Shift-right multiplier for |change| * q; low product bits shift into r_mv.
    assign w_mul_sum = {1'b0, r_acc_q} + (r_mv[0] ? {1'b0, r_q} : {SW{1'b0}});

    // Product >> F, saturated to 32 bits, then added to the first part.
    assign w_pb_sat  = |r_acc_q[ERR_BITS-1:ERR_BITS-SAMPLE_BITS];
    assign w_pb      = w_pb_sat ? {ERR_BITS{1'b1}}
                                : {r_acc_q[ERR_BITS-SAMPLE_BITS-1:0], r_mv[EW-1:FRACTION_BITS]};
    assign w_p_total = {1'b0, r_pa} + {1'b0, w_pb};

    assign o_done     = (r_state == F_DONE);
    assign o_estimate = r_est_next;
    assign o_gain     = r_gain;
    assign o_error    = w_p_total[ERR_BITS] ? {ERR_BITS{1'b1}} : w_p_total[ERR_BITS-1:0];

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == CW'(FRACTION_BITS)) begin
                    n_state = F_MOVE;
                end
            end
            F_MOVE: n_state = F_MUL;
            F_MUL: begin
                if (r_cnt == CW'(EW - 1)) begin
                    n_state = F_DONE;
                end
            end
            F_DONE: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    r_est   <= i_estimate;
                    r_p     <= i_error;
                    r_q     <= i_proc_noise;
                    r_sum   <= w_sum;
                    r_zero  <= (w_sum == '0);
                    r_rem   <= {2'b00, i_error};
                    r_up    <= (w_meas >= i_estimate);
                    r_dmag  <= (w_meas >= i_estimate) ? (w_meas - i_estimate)
                                                      : (i_estimate - w_meas);
                    r_acc_m <= '0;
                    r_acc_p <= '0;
                    r_gain  <= '0;
                    r_cnt   <= '0;
                end
            end
            F_DIV: begin
                r_rem   <= {w_rem_sub[RW-2:0], 1'b0};
                r_gain  <= {r_gain[GW-2:0], w_qbit};
                r_acc_m <= {r_acc_m[MW-2:0], 1'b0} + (w_qbit ? MW'(r_dmag) : {MW{1'b0}});
                r_acc_p <= {r_acc_p[PW-2:0], 1'b0} + (w_qbit ? PW'(r_p) : {PW{1'b0}});
                r_cnt   <= r_cnt + 1'b1;
            end
            F_MOVE: begin
                r_est_next <= w_est_move;
                r_pa       <= w_pa_diff[ERR_BITS+FRACTION_BITS-1:FRACTION_BITS];
                r_mv       <= w_mv;
                r_acc_q    <= '0;
                r_cnt      <= '0;
                if (r_zero) begin
                    r_gain <= '0;
                end
            end
            F_MUL: begin
                r_acc_q <= w_mul_sum[ERR_BITS:1];
                r_mv    <= {w_mul_sum[0], r_mv[EW-1:1]};
                r_cnt   <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/filtered_voltage_engine_detect_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// filtered_voltage_engine_detect_unit: engine detector on a filtered supply
// Kalman-filters the supply-voltage samples and debounces a threshold test to
// drive the starter relay and the side-marker brightness.
// ---------------------------------------------------------------------------
// One sample word is worked on at a time. A word with hazard_on set is taken
// and dropped without a result. Any other word is filtered in full before the
// next word is accepted. The gain comes from a restoring divider at one bit per
// cycle, which also steps the two shift-add multipliers for the estimate and
// error updates; the move step forms the new estimate, and the process noise
// product runs one bit of the estimate change per cycle. The finished word then
// goes to the output register and the block returns to idle. The result
// sits in an output register, so the next sample is taken while it waits; a
// result that finds the output still occupied holds the block until it drains.
// Configuration writes are always ready and are meant for idle periods;
// writing the initial estimate error also reloads the running estimate error.
module filtered_voltage_engine_detect_unit import fved_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Sample words.
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [SAMPLE_BITS-1:0]               i_adc_sample,
    input  logic                                 i_hazard_on,
    input  logic                                 i_left_blinker_on,
    input  logic                                 i_right_blinker_on,
    // Result words.
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] o_filtered_level,
    output logic [FRACTION_BITS:0]               o_gain_value,
    output logic                                 o_starter_on,
    output logic [BRIGHT_BITS-1:0]               o_side_brightness,
    output logic                                 o_left_drive_write,
    output logic                                 o_right_drive_write,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]            i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]             i_cfg_data
);

    localparam int EW = SAMPLE_BITS + FRACTION_BITS;

    t_tstate                 r_state;
    t_tstate                 n_state;

    // Configuration registers.
    logic [ERR_BITS-1:0]     r_meas_err;
    logic [ERR_BITS-1:0]     r_proc_noise;
    logic [SAMPLE_BITS-1:0]  r_threshold;
    logic [COUNT_BITS-1:0]   r_debounce;
    logic                    r_lock;

    // Filter and debounce state.
    logic [EW-1:0]           r_estimate;
    logic [ERR_BITS-1:0]     r_error;
    logic [COUNT_BITS-1:0]   r_run;
    logic [COUNT_BITS-1:0]   r_stop;
    logic                    r_relay;
    logic [BRIGHT_BITS-1:0]  r_bright;
    logic                    r_left_on;
    logic                    r_right_on;

    // Output register.
    logic                    r_out_valid;
    logic [EW-1:0]           r_out_level;
    logic [FRACTION_BITS:0]  r_out_gain;
    logic                    r_out_starter;
    logic [BRIGHT_BITS-1:0]  r_out_bright;
    logic                    r_out_left;
    logic                    r_out_right;

    logic                    w_in_accept;
    logic                    w_start;
    logic                    w_commit;
    logic                    w_cfg_write;
    logic                    w_above;
    logic                    f_done;
    logic [EW-1:0]           f_estimate;
    logic [FRACTION_BITS:0]  f_gain;
    logic [ERR_BITS-1:0]     f_error;
    logic [COUNT_BITS-1:0]   n_run;
    logic [COUNT_BITS-1:0]   n_stop;
    logic                    n_relay;
    logic [BRIGHT_BITS-1:0]  n_bright;

    assign o_ready     = (r_state == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_valid && o_ready;
    assign w_start     = w_in_accept && !i_hazard_on;
    assign w_commit    = (r_state == T_HOLD) && (!r_out_valid || i_ready);
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // Serial Kalman datapath.
    fved_filter #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_sample     (i_adc_sample),
        .i_estimate   (r_estimate),
        .i_error      (r_error),
        .i_meas_error (r_meas_err),
        .i_proc_noise (r_proc_noise),
        .o_done       (f_done),
        .o_estimate   (f_estimate),
        .o_gain       (f_gain),
        .o_error      (f_error)
    );

    // Control sequence: idle, filter running, result waiting for the output slot.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (w_start) begin
                    n_state = T_RUN;
                end
            end
            T_RUN: begin
                if (f_done) begin
                    n_state = T_HOLD;
                end
            end
            T_HOLD: begin
                if (w_commit) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    // Threshold test on the new estimate and the debounce counters.
    assign w_above = (f_estimate[EW-1:FRACTION_BITS] >= r_threshold);

    always_comb begin
        n_run    = r_run;
        n_stop   = r_stop;
        n_relay  = r_relay;
        n_bright = r_bright;
        if (w_above) begin
            n_stop = '0;
            if (r_run > r_debounce) begin
                if (r_lock) begin
                    n_relay = 1'b0;
                end
                n_bright = BRIGHT_RUN;
            end
            if (r_run != {COUNT_BITS{1'b1}}) begin
                n_run = r_run + 1'b1;
            end
        end else begin
            n_run = '0;
            if (r_stop > r_debounce) begin
                if (r_lock) begin
                    n_relay = 1'b1;
                end
                n_bright = BRIGHT_STOP;
            end
            if (r_stop != {COUNT_BITS{1'b1}}) begin
                n_stop = r_stop + 1'b1;
            end
        end
    end

    // Control state, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_out_valid  <= 1'b0;
            r_meas_err   <= RST_MEAS_ERR;
            r_proc_noise <= RST_PROC_NOISE;
            r_threshold  <= SAMPLE_BITS'(RST_THRESHOLD);
            r_debounce   <= RST_DEBOUNCE;
            r_lock       <= RST_LOCK;
            r_estimate   <= '0;
            r_error      <= RST_INIT_ERR;
            r_run        <= '0;
            r_stop       <= '0;
            r_relay      <= 1'b0;
            r_bright     <= BRIGHT_RUN;
        end else begin
            r_state <= n_state;

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_commit) begin
                r_estimate <= f_estimate;
                r_error    <= f_error;
                r_run      <= n_run;
                r_stop     <= n_stop;
                r_relay    <= n_relay;
                r_bright   <= n_bright;
            end

            if (w_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_MEAS_ERR:   r_meas_err   <= i_cfg_data[ERR_BITS-1:0];
                    CFG_INIT_ERR:   r_error      <= i_cfg_data[ERR_BITS-1:0];
                    CFG_PROC_NOISE: r_proc_noise <= i_cfg_data[ERR_BITS-1:0];
                    CFG_THRESHOLD:  r_threshold  <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_LOCK:       r_lock       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Blinker flags of the word in flight, and the output payload.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_left_on  <= i_left_blinker_on;
            r_right_on <= i_right_blinker_on;
        end
        if (w_commit) begin
            r_out_level   <= f_estimate;
            r_out_gain    <= f_gain;
            r_out_starter <= n_relay;
            r_out_bright  <= n_bright;
            r_out_left    <= !r_left_on;
            r_out_right   <= !r_right_on;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_filtered_level    = r_out_level;
    assign o_gain_value        = r_out_gain;
    assign o_starter_on        = r_out_starter;
    assign o_side_brightness   = r_out_bright;
    assign o_left_drive_write  = r_out_left;
    assign o_right_drive_write = r_out_right;

endmodule
`default_nettype wire

// ===== src/fved_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fved_checker: port-level checks of the engine detector
// Watches the handshakes and result words of the top level over time.
// ---------------------------------------------------------------------------
module fved_checker import fved_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 i_hazard_on,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [SAMPLE_BITS+FRACTION_BITS-1:0] o_filtered_level,
    input logic [FRACTION_BITS:0]               o_gain_value,
    input logic [BRIGHT_BITS-1:0]               o_side_brightness
);

    localparam logic [FRACTION_BITS:0] GAIN_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Brightness only ever takes its running or stopped level.
    a_bright_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_side_brightness == BRIGHT_RUN || o_side_brightness == BRIGHT_STOP))
        else $error("side brightness is neither the run nor the stop level");

    // The gain never exceeds one.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain_value <= GAIN_ONE))
        else $error("gain above one");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered_level)
                                   && $stable(o_gain_value)))
        else $error("stalled result word changed");

    // A sample word that is filtered keeps the block busy in the next cycle.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_hazard_on) |=> !o_ready)
        else $error("ready right after taking a sample word");

    // A hazard word is dropped without work.
    a_hazard_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_hazard_on) |=> o_ready)
        else $error("hazard word started the filter");

endmodule

bind filtered_voltage_engine_detect_unit fved_checker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_fved_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_hazard_on       (i_hazard_on),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_filtered_level  (o_filtered_level),
    .o_gain_value      (o_gain_value),
    .o_side_brightness (o_side_brightness)
);
`default_nettype wire
